// File: hdl/assert_macros.svh
// Assertion helpers used by the list engine top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ALIE_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("list engine check failed");

// A cause in one cycle and its effect in the next.
`define ALIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine sequence check failed");

`endif

// File: hdl/alie_pkg.sv
`timescale 1ns / 1ps

package alie_pkg;

    // List depth and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    // Request kinds.
    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_ERASE      = 3'd5,
        REQ_FIND       = 3'd6
    } req_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_POS_RANGE = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic  we;
        logic  ins;
        logic  del;
        cnt_t  pos;
        cnt_t  count;
        data_t value;
    } cell_cmd_t;

endpackage

// File: hdl/alie_cell.sv
`timescale 1ns / 1ps

module alie_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  alie_pkg::idx_t     idx,
    input  alie_pkg::cell_cmd_t cmd,
    input  alie_pkg::data_t    left_entry,
    input  alie_pkg::data_t    right_entry,
    output alie_pkg::data_t    entry,
    output logic               match
);

    alie_pkg::data_t entry_reg;
    alie_pkg::data_t entry_next;
    logic            match_reg;
    logic            match_next;
    alie_pkg::cnt_t  idx_ext;

    assign idx_ext = alie_pkg::cnt_t'(idx);

    // Insert loads the new word at the position and moves later words up;
    // erase pulls the words above the position down by one.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.we && cmd.ins)
        begin
            if (idx_ext == cmd.pos)
                entry_next = cmd.value;
            else if (idx_ext > cmd.pos)
                entry_next = left_entry;
        end
        else if (cmd.we && cmd.del)
        begin
            if (idx_ext >= cmd.pos)
                entry_next = right_entry;
        end
    end

    // The key compare is taken against the contents before any update.
    always_comb
    begin
        match_next = match_reg;
        if (cmd.we)
            match_next = (entry_reg == cmd.value) && (idx_ext < cmd.count);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// File: hdl/array_list_insert_erase_find.sv
`timescale 1ns / 1ps

// Bounded ordered list of 32-bit words held in a row of cells, one word per
// cell. The engine accepts every request (push, pop, insert, erase, find) and
// takes a new word in every cycle while the master side keeps up. At the
// accepting edge all cells shift in parallel and latch their key compare, and
// the status and count of the request are registered; once the output register
// is free, the row of compare bits is priority encoded into it, and the result
// word is then valid on the master side until it is taken. The list is empty
// after reset; no clearing is needed.

`include "assert_macros.svh"

module array_list_insert_erase_find (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zero [39:37]
    input  logic [2:0]  s_tuser,   // req_type [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status [2:0], found_index [6:3],
                                   // count [11:7], zero [15:12]
);

    localparam alie_pkg::cnt_t CAP_CNT = alie_pkg::cnt_t'(alie_pkg::CAPACITY);

    logic                 accept;
    logic                 out_free;
    alie_pkg::req_t       req;
    alie_pkg::cnt_t       in_pos;
    alie_pkg::data_t      in_value;

    alie_pkg::cnt_t       count_reg;
    alie_pkg::cnt_t       count_next;
    alie_pkg::status_t    status_c;
    alie_pkg::cell_cmd_t  cmd;

    logic                 pend_reg;
    logic                 pend_next;
    logic                 pfind_reg;
    alie_pkg::status_t    pstatus_reg;
    alie_pkg::cnt_t       pcount_reg;

    logic                 mvalid_reg;
    logic                 mvalid_next;
    alie_pkg::status_t    mstatus_reg;
    alie_pkg::idx_t       mfound_reg;
    alie_pkg::cnt_t       mcount_reg;

    alie_pkg::status_t    res_status;
    alie_pkg::idx_t       res_found;
    logic                 any_match;

    alie_pkg::data_t      entry  [alie_pkg::CAPACITY];
    logic [alie_pkg::CAPACITY-1:0] match;

    // Input word unpacking and handshake.
    assign req      = alie_pkg::req_t'(s_tuser);
    assign in_pos   = s_tdata[4:0];
    assign in_value = s_tdata[36:5];
    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // Request decode: range checks, shift command and the new count.
    always_comb
    begin
        status_c   = alie_pkg::ST_OK;
        count_next = count_reg;
        cmd.we     = accept;
        cmd.ins    = 1'b0;
        cmd.del    = 1'b0;
        cmd.pos    = in_pos;
        cmd.count  = count_reg;
        cmd.value  = in_value;
        unique case (req)
            alie_pkg::REQ_PUSH_BACK, alie_pkg::REQ_PUSH_FRONT, alie_pkg::REQ_INSERT:
            begin
                if (count_reg == CAP_CNT)
                    status_c = alie_pkg::ST_FULL;
                else if (req == alie_pkg::REQ_INSERT && in_pos > count_reg)
                    status_c = alie_pkg::ST_POS_RANGE;
                else
                begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + alie_pkg::cnt_t'(1);
                    if (req == alie_pkg::REQ_PUSH_BACK)
                        cmd.pos = count_reg;
                    else if (req == alie_pkg::REQ_PUSH_FRONT)
                        cmd.pos = '0;
                end
            end
            alie_pkg::REQ_POP_BACK, alie_pkg::REQ_POP_FRONT:
            begin
                if (count_reg == '0)
                    status_c = alie_pkg::ST_EMPTY;
                else
                begin
                    // Popping the back only drops the count.
                    cmd.del    = (req == alie_pkg::REQ_POP_FRONT);
                    cmd.pos    = '0;
                    count_next = count_reg - alie_pkg::cnt_t'(1);
                end
            end
            alie_pkg::REQ_ERASE:
            begin
                if (in_pos >= count_reg)
                    status_c = alie_pkg::ST_POS_RANGE;
                else
                begin
                    cmd.del    = 1'b1;
                    count_next = count_reg - alie_pkg::cnt_t'(1);
                end
            end
            default:
            begin
                // Find and the unused code change nothing here.
                status_c = alie_pkg::ST_OK;
            end
        endcase
    end

    // Row of cells; each one sees its neighbors, the input value left of the first and zero right of the last.
    genvar gi;
    generate
        for (gi = 0; gi < alie_pkg::CAPACITY; gi++)
        begin : g_cell
            alie_pkg::data_t left_w;
            alie_pkg::data_t right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = in_value;
            end
            else
            begin : g_mid_l
                assign left_w = entry[gi-1];
            end

            if (gi == alie_pkg::CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = entry[gi+1];
            end

            alie_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .idx         (alie_pkg::idx_t'(gi)),
                .cmd         (cmd),
                .left_entry  (left_w),
                .right_entry (right_w),
                .entry       (entry[gi]),
                .match       (match[gi])
            );
        end
    endgenerate

    // First matching cell, lowest index wins.
    always_comb
    begin
        res_found = '0;
        any_match = |match;
        for (int k = alie_pkg::CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k])
                res_found = alie_pkg::idx_t'(k);
        end
    end

    // Result of the pending request.
    always_comb
    begin
        res_status = pstatus_reg;
        if (pfind_reg)
            res_status = any_match ? alie_pkg::ST_OK : alie_pkg::ST_NOT_FOUND;
    end

    always_comb
    begin
        if (accept)
            pend_next = 1'b1;
        else if (out_free)
            pend_next = 1'b0;
        else
            pend_next = pend_reg;
    end

    always_comb
    begin
        if (pend_reg && out_free)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
        else
            mvalid_next = mvalid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Pending request and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pfind_reg   <= (req == alie_pkg::REQ_FIND);
            pstatus_reg <= status_c;
            pcount_reg  <= count_next;
        end
        if (pend_reg && out_free)
        begin
            mstatus_reg <= res_status;
            mfound_reg  <= (pfind_reg && any_match) ? res_found : '0;
            mcount_reg  <= pcount_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0000, mcount_reg, mfound_reg, mstatus_reg};

    `ALIE_ASSERT(a_count_bound, count_reg <= CAP_CNT)
    `ALIE_ASSERT_NEXT(a_accept_pends, accept, pend_reg)
    `ALIE_ASSERT_NEXT(a_pend_to_out, pend_reg && out_free, m_tvalid)
    `ALIE_ASSERT(a_miss_index_zero,
                 !(mvalid_reg && mstatus_reg == alie_pkg::ST_NOT_FOUND) || mfound_reg == '0)

endmodule
